// ===== src/emme_pkg.sv =====
`default_nettype none
package emme_pkg;

	localparam int EVENT_BITS_DEF = 32;
	localparam int COUNT_BITS = 16;
	localparam int FRAC_BITS = 16;
	localparam int PT_FRAC = 16;

	localparam logic [2:0] ACT_EV1 = 3'd0;
	localparam logic [2:0] ACT_EV2 = 3'd1;
	localparam logic [2:0] ACT_FIN1 = 3'd2;
	localparam logic [2:0] ACT_FIN2 = 3'd3;
	localparam logic [2:0] ACT_CLR = 3'd4;

	localparam logic [15:0] N_MASK = (COUNT_BITS >= 16) ? 16'hFFFF
		: 16'((64'd1 << COUNT_BITS) - 64'd1);

	localparam logic signed [63:0] INT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] INT_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [63:0] OUT_MIN = 64'shFFFF_8000_0000_0000;

	typedef enum logic [2:0] {
		OP_EV1,
		OP_EV2,
		OP_FIN1,
		OP_FIN2,
		OP_CLR,
		OP_BAD
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_BAD   = 2'd2,
		ST_SAT   = 2'd3
	} stat_t;

	typedef enum logic [4:0] {
		B_IDLE,
		B_EV1,
		B_EV1_ADD,
		B_EV2_A,
		B_EV2_B,
		B_EV2_ADD,
		B_F1_MC,
		B_F1_MSQ,
		B_F1_MPT,
		B_F1_MPTN,
		B_F1_PPP,
		B_F2_VAR,
		B_F2_COV,
		B_M2,
		B_F1_COV,
		B_DV_T,
		B_DV_Q,
		B_RV_Q,
		B_PUT
	} bst_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] n;
		logic [31:0] pt;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} qhead_t;

	typedef struct packed {
		logic               sat;
		logic signed [63:0] v;
	} sres_t;

	function automatic logic [63:0] mag64(input logic signed [63:0] x);
		mag64 = x[63] ? 64'(-x) : 64'(x);
	endfunction

	function automatic sres_t signed_sat(input logic [63:0] m, input logic neg);
		sres_t r;
		r.sat = 1'b0;
		if (!neg) begin
			if (m[63]) begin
				r.sat = 1'b1;
				r.v = INT_MAX;
			end else begin
				r.v = signed'(m);
			end
		end else begin
			if (m > 64'h8000_0000_0000_0000) begin
				r.sat = 1'b1;
				r.v = INT_MIN;
			end else begin
				r.v = -signed'(m);
			end
		end
		return r;
	endfunction

	function automatic sres_t ssub(input logic signed [63:0] a, input logic signed [63:0] b);
		sres_t r;
		logic [64:0] d;
		d = {a[63], a} - {b[63], b};
		r.sat = d[64] != d[63];
		if (r.sat) begin
			r.v = d[64] ? INT_MIN : INT_MAX;
		end else begin
			r.v = signed'(d[63:0]);
		end
		return r;
	endfunction

	function automatic sres_t sadd(input logic signed [63:0] a, input logic signed [63:0] b);
		sres_t r;
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		r.sat = s[64] != s[63];
		if (r.sat) begin
			r.v = s[64] ? INT_MIN : INT_MAX;
		end else begin
			r.v = signed'(s[63:0]);
		end
		return r;
	endfunction

	function automatic sres_t clamp48(input logic signed [63:0] x);
		sres_t r;
		r.sat = 1'b0;
		r.v = x;
		if (x > OUT_MAX) begin
			r.sat = 1'b1;
			r.v = OUT_MAX;
		end else if (x < OUT_MIN) begin
			r.sat = 1'b1;
			r.v = OUT_MIN;
		end
		return r;
	endfunction

	function automatic sres_t qmul_post(input logic [127:0] p, input logic neg);
		sres_t r;
		logic [127:0] s;
		logic [63:0] m;
		logic hi;
		s = (p + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		hi = s[127:64] != 64'd0;
		m = hi ? '1 : s[63:0];
		r = signed_sat(m, neg);
		r.sat = r.sat | hi;
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== src/emme_if.sv =====
`default_nettype none
interface emme_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [15:0] particle_count;
	logic [31:0] event_pt;

	modport source(output valid, action, particle_count, event_pt, input ready);
	modport sink(input valid, action, particle_count, event_pt, output ready);
endinterface

interface emme_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [31:0]        event_count;
	logic signed [47:0] mean_count;
	logic signed [47:0] count_variance;
	logic signed [47:0] mean_pt_total;
	logic signed [47:0] mean_pt_per_particle;
	logic signed [47:0] pt_count_covariance;
	logic signed [47:0] d_value;
	logic signed [47:0] r_value;

	modport source(output valid, status, event_count, mean_count, count_variance,
		mean_pt_total, mean_pt_per_particle, pt_count_covariance, d_value, r_value,
		input ready);
	modport sink(input valid, status, event_count, mean_count, count_variance,
		mean_pt_total, mean_pt_per_particle, pt_count_covariance, d_value, r_value,
		output ready);
endinterface
`default_nettype wire

// ===== src/emme_front.sv =====
`default_nettype none
module emme_front (
	input  logic            clk,
	input  logic            arst_n,
	emme_in_if.sink         events,
	output emme_pkg::qhead_t head,
	input  logic            pop
);
	import emme_pkg::*;

	item_t      mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	item_t      item;
	logic       push;

	always_comb begin
		item.n = events.particle_count & N_MASK;
		item.pt = events.event_pt;
		case (events.action)
			ACT_EV1:  item.op = OP_EV1;
			ACT_EV2:  item.op = OP_EV2;
			ACT_FIN1: item.op = OP_FIN1;
			ACT_FIN2: item.op = OP_FIN2;
			ACT_CLR:  item.op = OP_CLR;
			default:  item.op = OP_BAD;
		endcase
	end

	assign events.ready = cnt_q != 2'd2;
	assign push = events.valid && events.ready;
	assign head.valid = cnt_q != 2'd0;
	assign head.item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// ===== src/emme_mul.sv =====
`default_nettype none
module emme_mul (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic         done,
	output logic [127:0] prod
);
	logic [63:0]  a_q;
	logic [63:0]  b_q;
	logic [63:0]  pp_q;
	logic [1:0]   pidx_q;
	logic         pv_q;
	logic [2:0]   step_q;
	logic         busy_q;
	logic         done_q;
	logic [127:0] acc_q;
	logic [31:0]  a_part;
	logic [31:0]  b_part;
	logic [127:0] pp_shift;

	assign a_part = step_q[1] ? a_q[63:32] : a_q[31:0];
	assign b_part = step_q[0] ? b_q[63:32] : b_q[31:0];

	always_comb begin
		case (pidx_q)
			2'd0:    pp_shift = 128'(pp_q);
			2'd3:    pp_shift = 128'(pp_q) << 64;
			default: pp_shift = 128'(pp_q) << 32;
		endcase
	end

	assign done = done_q;
	assign prod = acc_q;

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			pp_q <= 64'(a_part) * 64'(b_part);
			pidx_q <= step_q[1:0];
			if (pv_q) begin
				acc_q <= acc_q + pp_shift;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			pv_q <= 1'b0;
			step_q <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				pv_q <= 1'b0;
				step_q <= 3'd0;
			end else if (busy_q) begin
				pv_q <= step_q != 3'd4;
				if (step_q != 3'd4) begin
					step_q <= step_q + 3'd1;
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== src/emme_div.sv =====
`default_nettype none
module emme_div (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] num,
	input  logic [63:0]  den,
	output logic         done,
	output logic [63:0]  quo,
	output logic         sat
);
	logic [127:0] nr;
	logic [63:0]  den_q;
	logic [63:0]  rem_q;
	logic [63:0]  lo_q;
	logic [63:0]  quo_q;
	logic         sat_q;
	logic [6:0]   cnt_q;
	logic         busy_q;
	logic         done_q;
	logic [64:0]  trial;
	logic         take;

	assign nr = num + 128'(den >> 1);
	assign trial = {rem_q, lo_q[63]};
	assign take = trial >= {1'b0, den_q};

	assign done = done_q;
	assign quo = quo_q;
	assign sat = sat_q;

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= nr[127:64];
			lo_q <= nr[63:0];
			if (den == 64'd0) begin
				quo_q <= '0;
				sat_q <= 1'b0;
			end else if (nr[127:64] >= den) begin
				quo_q <= '1;
				sat_q <= 1'b1;
			end else begin
				quo_q <= '0;
				sat_q <= 1'b0;
			end
		end else if (busy_q) begin
			rem_q <= take ? 64'(trial - {1'b0, den_q}) : trial[63:0];
			lo_q <= {lo_q[62:0], 1'b0};
			quo_q <= {quo_q[62:0], take};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 7'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (den == 64'd0 || nr[127:64] >= den) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q <= 7'd64;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== src/emme_back.sv =====
`default_nettype none
module emme_back #(
	parameter int EVENT_BITS = emme_pkg::EVENT_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  emme_pkg::qhead_t head,
	output logic             pop,
	emme_out_if.source       results
);
	import emme_pkg::*;

	bst_t state_q, state_d;
	item_t cur_q;

	logic [EVENT_BITS-1:0] ae_q;
	logic [47:0]           ct_q;
	logic [63:0]           cst_q, ptt_q, ptc_q, dst_q;
	logic signed [47:0]    smc_q, smp_q, sppp_q;
	logic signed [63:0]    dct_q;
	logic signed [63:0]    mc_q, msq_q, mpt_q, mptn_q, ppp_q, m2_q;
	logic signed [63:0]    var_q, cov_q, dv_q, rv_q, t_q, u_q;
	logic [31:0]           nn_q;
	logic [47:0]           pn_q;
	logic                  sat_q, fin_q, f1_q, launched_q;
	stat_t                 stat_q;

	logic               ov_q;
	stat_t              o_status_q;
	logic [31:0]        o_count_q;
	logic signed [47:0] o_mc_q, o_var_q, o_mpt_q, o_ppp_q, o_cov_q, o_dv_q, o_rv_q;

	logic [63:0]        ae64, ptden;
	logic signed [63:0] dn, dp, ptq;
	logic signed [63:0] mul_a, mul_b;
	logic [63:0]        div_num, div_den;
	logic               div_sh, div_neg;
	logic               is_mul, is_div, mul_start, div_start, mul_done, div_done, op_done;
	logic [127:0]       mul_prod, div_in;
	logic [63:0]        div_quo;
	logic               div_sat;
	sres_t              qm, dr, rvn;
	logic               load;
	sres_t              cv, cc, cd, cr, cm, cp, cq;
	logic               fin_sat;
	logic [48:0]        ct_sum;
	logic [64:0]        cst_sum, ptt_sum, ptc_sum, dst_sum;
	sres_t              dct_sum;

	assign ae64 = 64'(ae_q);
	assign ptden = ae64 << PT_FRAC;

	always_comb begin
		if (FRAC_BITS >= PT_FRAC) begin
			ptq = signed'(64'(cur_q.pt) << (FRAC_BITS - PT_FRAC));
		end else begin
			ptq = signed'((64'(cur_q.pt) + (64'd1 << (PT_FRAC - FRAC_BITS - 1)))
				>> (PT_FRAC - FRAC_BITS));
		end
	end

	assign dn = signed'(64'(cur_q.n) << FRAC_BITS) - 64'(smc_q);
	assign dp = ptq - 64'(smp_q);
	assign rvn = ssub(var_q, mc_q);

	always_comb begin
		mul_a = mc_q;
		mul_b = mc_q;
		div_num = '0;
		div_den = '0;
		div_sh = 1'b1;
		div_neg = 1'b0;
		is_mul = 1'b0;
		is_div = 1'b0;
		case (state_q)
			B_EV2_A: begin
				is_mul = 1'b1;
				mul_a = dn;
				mul_b = dn;
			end
			B_EV2_B: begin
				is_mul = 1'b1;
				mul_a = dp;
				mul_b = dn;
			end
			B_M2: begin
				is_mul = 1'b1;
			end
			B_F1_COV: begin
				is_mul = 1'b1;
				mul_a = mpt_q;
			end
			B_DV_T: begin
				is_mul = 1'b1;
				mul_a = ppp_q;
				mul_b = var_q;
			end
			B_F1_MC: begin
				is_div = 1'b1;
				div_num = 64'(ct_q);
				div_den = ae64;
			end
			B_F1_MSQ: begin
				is_div = 1'b1;
				div_num = cst_q;
				div_den = ae64;
			end
			B_F1_MPT: begin
				is_div = 1'b1;
				div_num = ptt_q;
				div_den = ptden;
			end
			B_F1_MPTN: begin
				is_div = 1'b1;
				div_num = ptc_q;
				div_den = ptden;
			end
			B_F1_PPP: begin
				is_div = 1'b1;
				div_num = mag64(mpt_q);
				div_den = mag64(mc_q);
				div_neg = mpt_q[63] ^ mc_q[63];
			end
			B_F2_VAR: begin
				is_div = 1'b1;
				div_num = dst_q;
				div_den = ae64;
				div_sh = 1'b0;
			end
			B_F2_COV: begin
				is_div = 1'b1;
				div_num = mag64(dct_q);
				div_den = ae64;
				div_sh = 1'b0;
				div_neg = dct_q[63];
			end
			B_DV_Q: begin
				is_div = 1'b1;
				div_num = mag64(t_q);
				div_den = mag64(m2_q);
				div_neg = t_q[63] ^ m2_q[63];
			end
			B_RV_Q: begin
				is_div = 1'b1;
				div_num = mag64(rvn.v);
				div_den = mag64(m2_q);
				div_neg = rvn.v[63] ^ m2_q[63];
			end
			default: begin
			end
		endcase
	end

	assign div_in = div_sh ? (128'(div_num) << FRAC_BITS) : 128'(div_num);
	assign mul_start = is_mul && !launched_q;
	assign div_start = is_div && !launched_q;
	assign op_done = (is_mul && mul_done) || (is_div && div_done);
	assign qm = qmul_post(mul_prod, mul_a[63] ^ mul_b[63]);
	assign dr = signed_sat(div_quo, div_neg);

	emme_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mag64(mul_a)),
		.b     (mag64(mul_b)),
		.done  (mul_done),
		.prod  (mul_prod)
	);

	emme_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_in),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo),
		.sat   (div_sat)
	);

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		load = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					case (head.item.op)
						OP_EV1:  state_d = (head.item.n != 16'd0) ? B_EV1 : B_PUT;
						OP_EV2:  state_d = (head.item.n != 16'd0) ? B_EV2_A : B_PUT;
						OP_FIN1: state_d = (ae_q != '0) ? B_F1_MC : B_PUT;
						OP_FIN2: state_d = (ae_q != '0) ? B_F2_VAR : B_PUT;
						default: state_d = B_PUT;
					endcase
				end
			end
			B_EV1:     state_d = B_EV1_ADD;
			B_EV1_ADD: state_d = B_PUT;
			B_EV2_A:   if (op_done) state_d = B_EV2_B;
			B_EV2_B:   if (op_done) state_d = B_EV2_ADD;
			B_EV2_ADD: state_d = B_PUT;
			B_F1_MC:   if (op_done) state_d = B_F1_MSQ;
			B_F1_MSQ:  if (op_done) state_d = B_F1_MPT;
			B_F1_MPT:  if (op_done) state_d = B_F1_MPTN;
			B_F1_MPTN: if (op_done) state_d = B_F1_PPP;
			B_F1_PPP:  if (op_done) state_d = B_M2;
			B_F2_VAR:  if (op_done) state_d = B_F2_COV;
			B_F2_COV:  if (op_done) state_d = B_M2;
			B_M2:      if (op_done) state_d = f1_q ? B_F1_COV : B_DV_T;
			B_F1_COV:  if (op_done) state_d = B_DV_T;
			B_DV_T:    if (op_done) state_d = B_DV_Q;
			B_DV_Q:    if (op_done) state_d = B_RV_Q;
			B_RV_Q:    if (op_done) state_d = B_PUT;
			B_PUT: begin
				if (!ov_q || results.ready) begin
					load = 1'b1;
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign ct_sum = {1'b0, ct_q} + 49'(cur_q.n);
	assign cst_sum = {1'b0, cst_q} + 65'(nn_q);
	assign ptt_sum = {1'b0, ptt_q} + 65'(cur_q.pt);
	assign ptc_sum = {1'b0, ptc_q} + 65'(pn_q);
	assign dst_sum = {1'b0, dst_q} + 65'(mag64(t_q));
	assign dct_sum = sadd(dct_q, u_q);

	assign cv = clamp48(var_q);
	assign cc = clamp48(cov_q);
	assign cd = clamp48(dv_q);
	assign cr = clamp48(rv_q);
	assign cm = clamp48(mc_q);
	assign cp = clamp48(mpt_q);
	assign cq = clamp48(ppp_q);
	assign fin_sat = fin_q && (cv.sat || cc.sat || cd.sat || cr.sat
		|| (f1_q && (cm.sat || cp.sat || cq.sat)));

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (head.valid) begin
					cur_q <= head.item;
					mc_q <= 64'(smc_q);
					ppp_q <= 64'(sppp_q);
				end
			end
			B_EV1: begin
				nn_q <= 32'(cur_q.n) * 32'(cur_q.n);
				pn_q <= 48'(cur_q.pt) * 48'(cur_q.n);
			end
			B_EV2_A:   if (op_done) t_q <= qm.v;
			B_EV2_B:   if (op_done) u_q <= qm.v;
			B_F1_MC:   if (op_done) mc_q <= dr.v;
			B_F1_MSQ:  if (op_done) msq_q <= dr.v;
			B_F1_MPT:  if (op_done) mpt_q <= dr.v;
			B_F1_MPTN: if (op_done) mptn_q <= dr.v;
			B_F1_PPP:  if (op_done) ppp_q <= dr.v;
			B_F2_VAR:  if (op_done) var_q <= dr.v;
			B_F2_COV:  if (op_done) cov_q <= dr.v;
			B_M2: begin
				if (op_done) begin
					m2_q <= qm.v;
					if (f1_q) begin
						var_q <= ssub(msq_q, qm.v).v;
					end
				end
			end
			B_F1_COV:  if (op_done) cov_q <= ssub(mptn_q, qm.v).v;
			B_DV_T:    if (op_done) t_q <= ssub(cov_q, qm.v).v;
			B_DV_Q:    if (op_done) dv_q <= dr.v;
			B_RV_Q:    if (op_done) rv_q <= dr.v;
			default: begin
			end
		endcase
		if (load) begin
			o_status_q <= (stat_q == ST_OK && (sat_q || fin_sat)) ? ST_SAT : stat_q;
			o_count_q <= (ae64 > 64'h0000_0000_FFFF_FFFF) ? '1 : ae64[31:0];
			o_mc_q <= (fin_q && f1_q) ? cm.v[47:0] : smc_q;
			o_mpt_q <= (fin_q && f1_q) ? cp.v[47:0] : smp_q;
			o_ppp_q <= (fin_q && f1_q) ? cq.v[47:0] : sppp_q;
			o_var_q <= fin_q ? cv.v[47:0] : '0;
			o_cov_q <= fin_q ? cc.v[47:0] : '0;
			o_dv_q <= fin_q ? cd.v[47:0] : '0;
			o_rv_q <= fin_q ? cr.v[47:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ae_q <= '0;
			ct_q <= '0;
			cst_q <= '0;
			ptt_q <= '0;
			ptc_q <= '0;
			smc_q <= '0;
			smp_q <= '0;
			sppp_q <= '0;
			dst_q <= '0;
			dct_q <= '0;
			sat_q <= 1'b0;
			fin_q <= 1'b0;
			f1_q <= 1'b0;
			stat_q <= ST_OK;
			launched_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (mul_start || div_start) begin
				launched_q <= 1'b1;
			end else if (op_done) begin
				launched_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (head.valid) begin
						sat_q <= 1'b0;
						f1_q <= head.item.op == OP_FIN1;
						fin_q <= (head.item.op == OP_FIN1 || head.item.op == OP_FIN2)
							&& ae_q != '0;
						if ((head.item.op == OP_FIN1 || head.item.op == OP_FIN2)
							&& ae_q == '0) begin
							stat_q <= ST_EMPTY;
						end else if (head.item.op == OP_BAD) begin
							stat_q <= ST_BAD;
						end else begin
							stat_q <= ST_OK;
						end
						if (head.item.op == OP_CLR) begin
							ae_q <= '0;
							ct_q <= '0;
							cst_q <= '0;
							ptt_q <= '0;
							ptc_q <= '0;
							smc_q <= '0;
							smp_q <= '0;
							sppp_q <= '0;
							dst_q <= '0;
							dct_q <= '0;
						end
					end
				end
				B_EV1_ADD: begin
					ae_q <= (ae_q == '1) ? ae_q : ae_q + 1'b1;
					ct_q <= ct_sum[48] ? '1 : ct_sum[47:0];
					cst_q <= cst_sum[64] ? '1 : cst_sum[63:0];
					ptt_q <= ptt_sum[64] ? '1 : ptt_sum[63:0];
					ptc_q <= ptc_sum[64] ? '1 : ptc_sum[63:0];
					sat_q <= sat_q || ae_q == '1 || ct_sum[48] || cst_sum[64]
						|| ptt_sum[64] || ptc_sum[64];
				end
				B_EV2_ADD: begin
					dst_q <= dst_sum[64] ? '1 : dst_sum[63:0];
					dct_q <= dct_sum.v;
					sat_q <= sat_q || dst_sum[64] || dct_sum.sat;
				end
				B_EV2_A, B_EV2_B, B_F1_COV, B_DV_T: begin
					if (op_done) begin
						sat_q <= sat_q || qm.sat
							|| (state_q == B_F1_COV && ssub(mptn_q, qm.v).sat)
							|| (state_q == B_DV_T && ssub(cov_q, qm.v).sat);
					end
				end
				B_M2: begin
					if (op_done) begin
						sat_q <= sat_q || qm.sat || (f1_q && ssub(msq_q, qm.v).sat);
					end
				end
				B_RV_Q: begin
					if (op_done) begin
						sat_q <= sat_q || div_sat || dr.sat || rvn.sat;
					end
				end
				B_F1_MC, B_F1_MSQ, B_F1_MPT, B_F1_MPTN, B_F1_PPP,
				B_F2_VAR, B_F2_COV, B_DV_Q: begin
					if (op_done) begin
						sat_q <= sat_q || div_sat || dr.sat;
					end
				end
				B_PUT: begin
					if (load && fin_q && f1_q) begin
						smc_q <= cm.v[47:0];
						smp_q <= cp.v[47:0];
						sppp_q <= cq.v[47:0];
					end
				end
				default: begin
				end
			endcase
			if (load) begin
				ov_q <= 1'b1;
			end else if (results.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign results.valid = ov_q;
	assign results.status = o_status_q;
	assign results.event_count = o_count_q;
	assign results.mean_count = o_mc_q;
	assign results.count_variance = o_var_q;
	assign results.mean_pt_total = o_mpt_q;
	assign results.mean_pt_per_particle = o_ppp_q;
	assign results.pt_count_covariance = o_cov_q;
	assign results.d_value = o_dv_q;
	assign results.r_value = o_rv_q;
endmodule
`default_nettype wire

// ===== src/event_multiplicity_moment_engine.sv =====
// Two-pass multiplicity moment engine: one result word per input word, in order.
// A front queue of two words takes input while the back end works. Event words
// of the first pass only add to running sums; those of the second pass run two
// 64x64 multiplies, each four 32x32 partial products on one shared multiplier.
// Finish words run on one shared divider that retires one quotient bit a cycle:
// a first-pass finish costs seven divisions and three multiplies; a second-pass
// finish four divisions and two multiplies. Clear, invalid, zero-count and
// empty-finish words skip the arithmetic. Every word can also wait in its last
// state while the result port stalls.
// The result register holds a word until taken while the next word is started.
`default_nettype none
module event_multiplicity_moment_engine #(
	parameter int EVENT_BITS = emme_pkg::EVENT_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	emme_in_if.sink    events,
	emme_out_if.source results
);
	import emme_pkg::*;

	qhead_t head;
	logic   pop;

	emme_front u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.events(events),
		.head  (head),
		.pop   (pop)
	);

	emme_back #(
		.EVENT_BITS(EVENT_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.results(results)
	);
endmodule
`default_nettype wire

// ===== verif/tb_event_multiplicity_moment_engine.sv =====
module tb_event_multiplicity_moment_engine;
	import emme_pkg::*;

	localparam logic [2:0] ACT_BAD_LO = 3'd5;
	localparam logic [2:0] ACT_BAD_HI = 3'd7;
	localparam int IDLE_LIMIT = 40000;
	localparam int DRAIN_CYCLES = 1200;
	localparam logic [63:0] ALL1 = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] EV_MAX = 64'hFFFF_FFFF;
	localparam logic [63:0] CNT_MAX = 64'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] n;
		logic [31:0] pt;
	} ev_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] event_count;
		logic [47:0] mean_count;
		logic [47:0] count_variance;
		logic [47:0] mean_pt_total;
		logic [47:0] mean_pt_per_particle;
		logic [47:0] pt_count_covariance;
		logic [47:0] d_value;
		logic [47:0] r_value;
	} moments_t;

	logic clk;
	logic arst_n;
	emme_in_if ev();
	emme_out_if res();

	event_multiplicity_moment_engine uut (
		.clk(clk),
		.arst_n(arst_n),
		.events(ev),
		.results(res)
	);

	ev_word_t pending_words[$];
	moments_t expected_moments[$];
	int errors = 0;

	// predictor state
	logic [63:0] n_events, cnt_sum, cnt_sq_sum, pt_sum, pt_cnt_sum, dev_sq_sum;
	logic signed [63:0] avg_cnt, avg_pt, avg_ppp, dev_x_sum;
	logic sat_seen;

	function automatic logic [63:0] mag(input logic signed [63:0] x);
		return x[63] ? 64'(-x) : 64'(x);
	endfunction

	function automatic logic [63:0] acc_sat(input logic [63:0] acc, input logic [63:0] v,
			input logic [63:0] lim);
		if (acc > lim || v > lim - acc) begin
			sat_seen = 1'b1;
			return lim;
		end
		return acc + v;
	endfunction

	function automatic logic signed [63:0] to_signed(input logic [63:0] m, input logic neg);
		if (!neg) begin
			if (m[63]) begin
				sat_seen = 1'b1;
				return INT_MAX;
			end
			return signed'(m);
		end
		if (m > 64'h8000_0000_0000_0000) begin
			sat_seen = 1'b1;
			return INT_MIN;
		end
		return -signed'(m);
	endfunction

	function automatic logic [63:0] div_round(input logic [127:0] num, input logic [63:0] d);
		logic [127:0] t;
		if (d == 0) return 0;
		t = num + {64'd0, d >> 1};
		if (t[127:64] >= d) begin
			sat_seen = 1'b1;
			return ALL1;
		end
		return 64'(t / {64'd0, d});
	endfunction

	function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic [127:0] p;
		logic [63:0] m;
		p = ({64'd0, mag(a)} * {64'd0, mag(b)} + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		if (p[127:64] != 0) begin
			sat_seen = 1'b1;
			m = ALL1;
		end else begin
			m = p[63:0];
		end
		return to_signed(m, a[63] != b[63]);
	endfunction

	function automatic logic signed [63:0] fx_div(input logic signed [63:0] a,
			input logic signed [63:0] b);
		if (b == 0) return 0;
		return to_signed(div_round({64'd0, mag(a)} << FRAC_BITS, mag(b)), a[63] != b[63]);
	endfunction

	function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			sat_seen = 1'b1;
			return s[64] ? INT_MIN : INT_MAX;
		end
		return signed'(s[63:0]);
	endfunction

	function automatic logic signed [63:0] sub_sat(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63]) begin
			sat_seen = 1'b1;
			return s[64] ? INT_MIN : INT_MAX;
		end
		return signed'(s[63:0]);
	endfunction

	function automatic logic signed [63:0] clip48(input logic signed [63:0] x);
		if (x > OUT_MAX) begin
			sat_seen = 1'b1;
			return OUT_MAX;
		end
		if (x < OUT_MIN) begin
			sat_seen = 1'b1;
			return OUT_MIN;
		end
		return x;
	endfunction

	function automatic void clear_moments();
		n_events = 0;
		cnt_sum = 0;
		cnt_sq_sum = 0;
		pt_sum = 0;
		pt_cnt_sum = 0;
		dev_sq_sum = 0;
		avg_cnt = 0;
		avg_pt = 0;
		avg_ppp = 0;
		dev_x_sum = 0;
	endfunction

	function automatic moments_t predict_moments(input ev_word_t w);
		moments_t r;
		logic [63:0] n, pt;
		logic signed [63:0] var_v, cov_v, d_v, r_v, m2, dn, dp, mc, msq, mpt, mptn, ppp;
		logic [1:0] st;
		n = {48'd0, w.n & N_MASK};
		pt = {32'd0, w.pt};
		var_v = 0;
		cov_v = 0;
		d_v = 0;
		r_v = 0;
		st = ST_OK;
		sat_seen = 1'b0;
		case (w.action)
			ACT_EV1: begin
				if (n != 0) begin
					n_events = acc_sat(n_events, 64'd1, EV_MAX);
					cnt_sum = acc_sat(cnt_sum, n, CNT_MAX);
					cnt_sq_sum = acc_sat(cnt_sq_sum, n * n, ALL1);
					pt_sum = acc_sat(pt_sum, pt, ALL1);
					pt_cnt_sum = acc_sat(pt_cnt_sum, pt * n, ALL1);
				end
			end
			ACT_EV2: begin
				if (n != 0) begin
					dn = signed'(n << FRAC_BITS) - avg_cnt;
					dp = signed'(pt) - avg_pt;
					dev_sq_sum = acc_sat(dev_sq_sum, mag(fx_mul(dn, dn)), ALL1);
					dev_x_sum = add_sat(dev_x_sum, fx_mul(dp, dn));
				end
			end
			ACT_FIN1: begin
				if (n_events == 0) begin
					st = ST_EMPTY;
				end else begin
					mc = to_signed(div_round({64'd0, cnt_sum} << FRAC_BITS, n_events), 1'b0);
					msq = to_signed(div_round({64'd0, cnt_sq_sum} << FRAC_BITS, n_events), 1'b0);
					mpt = to_signed(div_round({64'd0, pt_sum} << FRAC_BITS,
						n_events << PT_FRAC), 1'b0);
					mptn = to_signed(div_round({64'd0, pt_cnt_sum} << FRAC_BITS,
						n_events << PT_FRAC), 1'b0);
					ppp = fx_div(mpt, mc);
					m2 = fx_mul(mc, mc);
					var_v = sub_sat(msq, m2);
					cov_v = sub_sat(mptn, fx_mul(mpt, mc));
					d_v = fx_div(sub_sat(cov_v, fx_mul(ppp, var_v)), m2);
					r_v = fx_div(sub_sat(var_v, mc), m2);
					avg_cnt = clip48(mc);
					avg_pt = clip48(mpt);
					avg_ppp = clip48(ppp);
				end
			end
			ACT_FIN2: begin
				if (n_events == 0) begin
					st = ST_EMPTY;
				end else begin
					var_v = to_signed(div_round({64'd0, dev_sq_sum}, n_events), 1'b0);
					cov_v = to_signed(div_round({64'd0, mag(dev_x_sum)}, n_events),
						dev_x_sum[63]);
					m2 = fx_mul(avg_cnt, avg_cnt);
					d_v = fx_div(sub_sat(cov_v, fx_mul(avg_ppp, var_v)), m2);
					r_v = fx_div(sub_sat(var_v, avg_cnt), m2);
				end
			end
			ACT_CLR: clear_moments();
			default: st = ST_BAD;
		endcase
		var_v = clip48(var_v);
		cov_v = clip48(cov_v);
		d_v = clip48(d_v);
		r_v = clip48(r_v);
		if (st == ST_OK && sat_seen) st = ST_SAT;
		r.status = st;
		r.event_count = n_events > EV_MAX ? 32'hFFFF_FFFF : n_events[31:0];
		r.mean_count = avg_cnt[47:0];
		r.count_variance = var_v[47:0];
		r.mean_pt_total = avg_pt[47:0];
		r.mean_pt_per_particle = avg_ppp[47:0];
		r.pt_count_covariance = cov_v[47:0];
		r.d_value = d_v[47:0];
		r.r_value = r_v[47:0];
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t %s expected %h actual %h", $time, name, exp_v, act_v);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver
	int burst_left = 0;
	int gap_left = 0;
	int accepts = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev.valid <= 1'b0;
			ev.action <= '0;
			ev.particle_count <= '0;
			ev.event_pt <= '0;
		end else if (!ev.valid || ev.ready) begin
			if (ev.valid) begin
				expected_moments.push_back(predict_moments(
					'{ev.action, ev.particle_count, ev.event_pt}));
				accepts++;
			end
			if (gap_left > 0) begin
				gap_left--;
				ev.valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				ev_word_t w;
				w = pending_words.pop_front();
				ev.valid <= 1'b1;
				ev.action <= w.action;
				ev.particle_count <= w.n;
				ev.event_pt <= w.pt;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 30);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
				end
			end else begin
				ev.valid <= 1'b0;
			end
		end
	end

	// monitor
	int stall_mode = 0;
	int mode_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			if (res.valid && res.ready) begin
				moments_t got, want;
				accepts++;
				got = '{res.status, res.event_count, res.mean_count, res.count_variance,
					res.mean_pt_total, res.mean_pt_per_particle, res.pt_count_covariance,
					res.d_value, res.r_value};
				if (expected_moments.size() == 0) begin
					errors++;
					$display("%0t unexpected result word status %h", $time, got.status);
				end else begin
					want = expected_moments.pop_front();
					check_field("status", want.status, got.status);
					check_field("event_count", want.event_count, got.event_count);
					check_field("mean_count", want.mean_count, got.mean_count);
					check_field("count_variance", want.count_variance, got.count_variance);
					check_field("mean_pt_total", want.mean_pt_total, got.mean_pt_total);
					check_field("mean_pt_per_particle", want.mean_pt_per_particle,
						got.mean_pt_per_particle);
					check_field("pt_count_covariance", want.pt_count_covariance,
						got.pt_count_covariance);
					check_field("d_value", want.d_value, got.d_value);
					check_field("r_value", want.r_value, got.r_value);
				end
			end
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(5, 200);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				0: res.ready <= 1'b1;
				1: res.ready <= 1'($urandom_range(0, 1));
				default: res.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// watchdog
	int idle_cycles = 0;
	int last_accepts = 0;
	always @(posedge clk) begin
		if (accepts != last_accepts) idle_cycles = 0;
		else idle_cycles++;
		last_accepts = accepts;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [15:0] pick_count();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(1, 65535));
			1: return 16'($urandom_range(1, 20));
			2: return 16'($urandom_range(65000, 65535));
			default: return 16'($urandom_range(1, 1000));
		endcase
	endfunction

	function automatic logic [31:0] pick_pt();
		case ($urandom_range(0, 2))
			0: return $urandom;
			1: return 32'($urandom_range(0, 32'h00FF_FFFF));
			default: return {8'd0, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535))};
		endcase
	endfunction

	initial begin
		ev_word_t set_words[$];
		ev_word_t w;
		int total;
		int k;
		clear_moments();
		pending_words = '{
			'{ACT_CLR, 16'd0, 32'd0},
			'{ACT_FIN1, 16'd0, 32'd0},
			'{ACT_FIN2, 16'd0, 32'd0},
			'{ACT_EV1, 16'd0, 32'hFFFF_FFFF},
			'{ACT_EV1, 16'hFFFF, 32'hFFFF_FFFF},
			'{ACT_EV1, 16'd1, 32'd0},
			'{ACT_FIN2, 16'hFFFF, 32'hFFFF_FFFF},
			'{ACT_FIN1, 16'd0, 32'd0},
			'{ACT_EV2, 16'hFFFF, 32'hFFFF_FFFF},
			'{ACT_EV2, 16'd1, 32'd0},
			'{ACT_EV2, 16'd0, 32'd5},
			'{ACT_FIN2, 16'd0, 32'd0},
			'{ACT_BAD_LO, 16'hFFFF, 32'hFFFF_FFFF},
			'{3'd6, 16'h5555, 32'hAAAA_AAAA},
			'{ACT_BAD_HI, 16'd0, 32'd0},
			'{ACT_CLR, 16'hFFFF, 32'hFFFF_FFFF},
			'{ACT_EV1, 16'd3, 32'h0003_0000},
			'{ACT_EV1, 16'd5, 32'h0001_8000},
			'{ACT_FIN1, 16'd0, 32'd0},
			'{ACT_EV2, 16'd3, 32'h0003_0000},
			'{ACT_EV2, 16'd5, 32'h0001_8000},
			'{ACT_FIN2, 16'd0, 32'd0}
		};
		total = pending_words.size();
		while (total < 1100) begin
			if ($urandom_range(0, 9) < 8) begin
				set_words = {};
				if ($urandom_range(0, 2) != 0) pending_words.push_back('{ACT_CLR, 16'd0, 32'd0});
				k = $urandom_range(1, 12);
				repeat (k) begin
					w = '{ACT_EV1, pick_count(), pick_pt()};
					if ($urandom_range(0, 9) == 0) w.n = 0;
					set_words.push_back(w);
					pending_words.push_back(w);
				end
				pending_words.push_back('{ACT_FIN1, 16'($urandom), $urandom});
				foreach (set_words[i]) begin
					w = set_words[i];
					w.action = ACT_EV2;
					pending_words.push_back(w);
				end
				pending_words.push_back('{ACT_FIN2, 16'($urandom), $urandom});
				total += 2 * k + 3;
			end else begin
				w = '{3'($urandom_range(0, 7)), 16'($urandom), $urandom};
				pending_words.push_back(w);
				total++;
			end
		end
		wait (arst_n);
		while (pending_words.size() > 0 || ev.valid || expected_moments.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
src/emme_pkg.sv
src/emme_if.sv
src/emme_front.sv
src/emme_mul.sv
src/emme_div.sv
src/emme_back.sv
src/event_multiplicity_moment_engine.sv
verif/tb_event_multiplicity_moment_engine.sv
